// File: design/ecte_pkg.sv
// Shared types and constants of the escape command text encoder.
`default_nettype none
package ecte_pkg;

   localparam int MEM_BYTES     = 128;
   localparam int PICTURE_SLOTS = 8;
   localparam int PIC_IDX_W     = (PICTURE_SLOTS > 1) ? $clog2(PICTURE_SLOTS) : 1;
   localparam int JOB_DEPTH     = 4;
   localparam int BEATS_PER_JOB = 3;
   localparam logic [6:0] MEM_LAST_ADDR = 7'(MEM_BYTES - 1);

   localparam logic CSR_EE_MODE    = 1'b0;
   localparam logic CSR_TEXT_LIMIT = 1'b1;

   localparam logic KIND_WRITE    = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   localparam logic ACTION_TEXT = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_ONE       = 8'h31;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UPPER_I   = 8'h49;
   localparam logic [7:0] CHAR_UPPER_H   = 8'h48;
   localparam logic [7:0] CHAR_UPPER_S   = 8'h53;
   localparam logic [7:0] CHAR_LOWER_S   = 8'h73;
   localparam logic [7:0] CHAR_UPPER_W   = 8'h57;
   localparam logic [7:0] CHAR_LOWER_W   = 8'h77;
   localparam logic [7:0] CHAR_UPPER_P   = 8'h50;
   localparam logic [7:0] CHAR_LOWER_P   = 8'h70;
   localparam logic [7:0] CHAR_UPPER_D   = 8'h44;
   localparam logic [7:0] CHAR_LOWER_D   = 8'h64;

   localparam logic [7:0] BYTE_SEPARATOR = 8'h00;
   localparam logic [7:0] BYTE_END       = 8'h01;
   localparam logic [7:0] BYTE_SPEED     = 8'h02;
   localparam logic [7:0] BYTE_INVERT    = 8'h0A;
   localparam logic [7:0] BYTE_HOLD      = 8'h0B;
   localparam logic [7:0] BYTE_WAIT      = 8'h0E;
   localparam logic [7:0] BYTE_PICTURE   = 8'h16;
   localparam logic [7:0] BYTE_SPACER    = 8'h1E;
   localparam logic [7:0] BYTE_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_SPEED,
      CMD_WAIT,
      CMD_PICTURE,
      CMD_SPACER,
      CMD_OTHER
   } cmd_letter_type;

   typedef struct packed {
      logic       action;
      logic [7:0] code;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] address;
      logic [7:0] data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic       kind;
      logic [6:0] address;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic [1:0]                       count;
      beat_type [BEATS_PER_JOB-1:0]     beats;
   } job_type;

endpackage
`default_nettype wire

// File: design/ecte_front.sv
// Front end: takes text items, tracks escape and picture state, builds write jobs.
`default_nettype none
module ecte_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [6:0]       csr_wdata,
   input  wire logic             item_valid,
   input  wire ecte_pkg::req_type item,
   output      logic             job_push,
   output      ecte_pkg::job_type job
);

   logic                    ee_mode_ff, ee_mode_in;
   logic [6:0]              text_limit_ff, text_limit_in;
   logic                    escape_ff, escape_in;
   ecte_pkg::cmd_letter_type letter_ff, letter_in;
   logic                    separated_ff, separated_in;
   logic                    sep_held_ff, sep_held_in;
   logic [7:0]              write_count_ff, write_count_in;
   logic                    started_ff, started_in;
   logic                    stopped_ff, stopped_in;
   logic [ecte_pkg::PICTURE_SLOTS-1:0] pic_valid_ff, pic_valid_in;
   logic [2:0]              pic_id_ff [ecte_pkg::PICTURE_SLOTS];
   logic [2:0]              pic_id_in [ecte_pkg::PICTURE_SLOTS];
   logic [3:0]              pic_count_ff, pic_count_in;

   logic [6:0]              limit;
   logic [8:0]              used;
   logic                    is_digit;
   logic [3:0]              num;
   logic [ecte_pkg::PIC_IDX_W-1:0] slot;
   logic [1:0]              n;
   ecte_pkg::beat_type [ecte_pkg::BEATS_PER_JOB-1:0] beats;

   assign limit    = (text_limit_ff > ecte_pkg::MEM_LAST_ADDR) ? ecte_pkg::MEM_LAST_ADDR
                                                               : text_limit_ff;
   assign is_digit = (item.code >= ecte_pkg::CHAR_ONE) && (item.code <= ecte_pkg::CHAR_NINE);
   assign num      = 4'(item.code - ecte_pkg::CHAR_ZERO);
   assign slot     = ecte_pkg::PIC_IDX_W'(num - 4'd1);

   always_comb begin
      ee_mode_in    = ee_mode_ff;
      text_limit_in = text_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            ecte_pkg::CSR_EE_MODE:    ee_mode_in    = csr_wdata[0];
            ecte_pkg::CSR_TEXT_LIMIT: text_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      escape_in      = escape_ff;
      letter_in      = letter_ff;
      separated_in   = separated_ff;
      sep_held_in    = sep_held_ff;
      write_count_in = write_count_ff;
      started_in     = started_ff;
      stopped_in     = stopped_ff;
      pic_valid_in   = pic_valid_ff;
      pic_id_in      = pic_id_ff;
      pic_count_in   = pic_count_ff;
      n              = 2'd0;
      beats          = '0;
      used           = '0;
      if (item_valid && !stopped_ff) begin
         if (!started_ff) begin
            started_in = 1'b1;
            if (ee_mode_ff) begin
               beats[0]       = '{ecte_pkg::KIND_WRITE, write_count_ff[6:0],
                                  ecte_pkg::BYTE_SPACE};
               beats[1]       = '{ecte_pkg::KIND_WRITE, 7'(write_count_ff + 8'd1),
                                  ecte_pkg::BYTE_SPACE};
               n              = 2'd2;
               write_count_in = write_count_ff + 8'd2;
               sep_held_in    = 1'b0;
            end
         end
         used = {1'b0, write_count_in} + {2'b00, pic_count_ff, 3'b000};
         if (item.action == ecte_pkg::ACTION_END) begin
            if (sep_held_in && (write_count_in != 8'd0)) begin
               beats[n]    = '{ecte_pkg::KIND_WRITE, 7'(write_count_in - 8'd1),
                               ecte_pkg::BYTE_END};
               n           = n + 2'd1;
               sep_held_in = 1'b0;
            end else begin
               beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                  ecte_pkg::BYTE_END};
               n              = n + 2'd1;
               sep_held_in    = 1'b0;
               write_count_in = write_count_in + 8'd1;
            end
            escape_in  = 1'b0;
            letter_in  = ecte_pkg::CMD_NONE;
            stopped_in = 1'b1;
         end else if (letter_ff != ecte_pkg::CMD_NONE) begin
            letter_in = ecte_pkg::CMD_NONE;
            if (is_digit) begin
               if ((letter_ff == ecte_pkg::CMD_SPEED) && (num <= 4'd8)) begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_SPEED + 8'(num) - 8'd1};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end else if ((letter_ff == ecte_pkg::CMD_WAIT) && (num <= 4'd8)) begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_WAIT + 8'(num) - 8'd1};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end else if ((letter_ff == ecte_pkg::CMD_PICTURE) &&
                            (num <= 4'(ecte_pkg::PICTURE_SLOTS))) begin
                  if (!pic_valid_ff[slot]) begin
                     pic_valid_in[slot] = 1'b1;
                     pic_id_in[slot]    = pic_count_ff[2:0];
                     pic_count_in       = pic_count_ff + 4'd1;
                  end
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_PICTURE + 8'(pic_id_in[slot])};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end else if ((letter_ff == ecte_pkg::CMD_SPACER) && (num <= 4'd2)) begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_SPACER + 8'(num) - 8'd1};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end
            end
         end else if (used >= {2'b00, limit}) begin
            beats[n]   = '{ecte_pkg::KIND_OVERFLOW, 7'd0, 8'd0};
            n          = n + 2'd1;
            stopped_in = 1'b1;
         end else if (escape_ff) begin
            escape_in = 1'b0;
            unique case (item.code) inside
               ecte_pkg::CHAR_BACKSLASH: begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::CHAR_BACKSLASH};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end
               ecte_pkg::CHAR_UPPER_I: begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_INVERT};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end
               ecte_pkg::CHAR_UPPER_H: begin
                  beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                     ecte_pkg::BYTE_HOLD};
                  n              = n + 2'd1;
                  sep_held_in    = 1'b0;
                  write_count_in = write_count_in + 8'd1;
               end
               ecte_pkg::CHAR_UPPER_S, ecte_pkg::CHAR_LOWER_S: letter_in = ecte_pkg::CMD_SPEED;
               ecte_pkg::CHAR_UPPER_W, ecte_pkg::CHAR_LOWER_W: letter_in = ecte_pkg::CMD_WAIT;
               ecte_pkg::CHAR_UPPER_P, ecte_pkg::CHAR_LOWER_P: letter_in = ecte_pkg::CMD_PICTURE;
               ecte_pkg::CHAR_UPPER_D, ecte_pkg::CHAR_LOWER_D: letter_in = ecte_pkg::CMD_SPACER;
               default: letter_in = ecte_pkg::CMD_OTHER;
            endcase
         end else if (item.code == ecte_pkg::CHAR_NEWLINE) begin
            if (separated_ff) begin
               separated_in = 1'b0;
            end else begin
               beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0],
                                  ecte_pkg::BYTE_SEPARATOR};
               n              = n + 2'd1;
               sep_held_in    = 1'b1;
               write_count_in = write_count_in + 8'd1;
               separated_in   = 1'b1;
            end
         end else begin
            separated_in = 1'b0;
            if (item.code == ecte_pkg::CHAR_BACKSLASH) begin
               escape_in = 1'b1;
            end else if (item.code >= ecte_pkg::BYTE_SPACE) begin
               beats[n]       = '{ecte_pkg::KIND_WRITE, write_count_in[6:0], item.code};
               n              = n + 2'd1;
               sep_held_in    = 1'b0;
               write_count_in = write_count_in + 8'd1;
            end
         end
      end
   end

   assign job_push  = item_valid && (n != 2'd0);
   assign job.count = n;
   assign job.beats = beats;

   always_ff @(posedge clock) begin
      if (reset) begin
         ee_mode_ff     <= 1'b0;
         text_limit_ff  <= 7'd127;
         escape_ff      <= 1'b0;
         letter_ff      <= ecte_pkg::CMD_NONE;
         separated_ff   <= 1'b0;
         sep_held_ff    <= 1'b0;
         write_count_ff <= 8'd0;
         started_ff     <= 1'b0;
         stopped_ff     <= 1'b0;
         pic_valid_ff   <= '0;
         pic_count_ff   <= 4'd0;
      end else begin
         ee_mode_ff     <= ee_mode_in;
         text_limit_ff  <= text_limit_in;
         escape_ff      <= escape_in;
         letter_ff      <= letter_in;
         separated_ff   <= separated_in;
         sep_held_ff    <= sep_held_in;
         write_count_ff <= write_count_in;
         started_ff     <= started_in;
         stopped_ff     <= stopped_in;
         pic_valid_ff   <= pic_valid_in;
         pic_count_ff   <= pic_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pic_id_ff <= pic_id_in;
   end

   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |=> stopped_ff)
      else $error("encoder left the stopped state without reset");

   a_pic_count: assert property (@(posedge clock) disable iff (reset)
      pic_count_ff <= 4'(ecte_pkg::PICTURE_SLOTS))
      else $error("more pictures than slots");

endmodule
`default_nettype wire

// File: design/ecte_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module ecte_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ecte_pkg::job_type wdata,
   input  wire logic              pop,
   output      ecte_pkg::job_type rdata,
   output      logic              full,
   output      logic              empty
);

   localparam int PtrW = $clog2(ecte_pkg::JOB_DEPTH);
   localparam int CntW = $clog2(ecte_pkg::JOB_DEPTH + 1);

   ecte_pkg::job_type slots_ff [ecte_pkg::JOB_DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(ecte_pkg::JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wdata;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(ecte_pkg::JOB_DEPTH))
      else $error("job queue count out of range");

endmodule
`default_nettype wire

// File: design/ecte_back.sv
// Back end: delivers each queued job one beat per cycle while rsp_pop takes them.
`default_nettype none
module ecte_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ecte_pkg::job_type head,
   input  wire logic              head_empty,
   output      logic              head_pop,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      ecte_pkg::rsp_type rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   ecte_pkg::rsp_type out_ff, out_in;
   logic              load;
   logic              is_last;
   ecte_pkg::beat_type beat;

   assign load    = !head_empty && (!valid_ff || rsp_pop);
   assign beat    = head.beats[idx_ff];
   assign is_last = (idx_ff == (head.count - 2'd1));
   assign head_pop = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_pop;
      out_in   = out_ff;
      if (load) begin
         valid_in = 1'b1;
         out_in   = '{beat.kind, beat.address, beat.data, is_last};
         idx_in   = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> (idx_ff < head.count))
      else $error("beat index past the end of the job");

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      head_empty |-> (idx_ff == 2'd0))
      else $error("beat index left over with no job");

endmodule
`default_nettype wire

// File: design/escape_command_text_encoder.sv
// Top level of the escape command text encoder.
// Usage:
//   Input side is a queue: drive req_data and push; the item is taken at a
//   rising edge with req_push high and req_full low. action 0 carries a text
//   code, action 1 marks end of text.
//   Result side is a queue: while rsp_empty is low, rsp_data holds the oldest
//   byte write (or the overflow error); raise rsp_pop to take it. last marks
//   the final beat caused by one item.
//   csr_we/csr_index/csr_wdata write ee_mode (index 0) and text_limit
//   (index 1); write only while the block is idle.
// Timing:
//   The front end takes one item per cycle while req_full is low and
//   classifies it in that cycle; the job it builds goes into the job queue,
//   then into the back end's output register, which drives rsp_data.
//   The back end emits one beat per cycle while rsp_pop takes them, 1-3
//   beats per item (two lead bytes plus one write at most). A four-entry job
//   queue decouples the two; items that cause no beat never enter it.
// Reset: synchronous; clears control state but not stored data, marks every
//   picture slot unused and returns ee_mode to 0 and text_limit to 127.
// Stall: when rsp_pop stays low the job queue fills and req_full rises.
`default_nettype none
module escape_command_text_encoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output      logic              req_full,
   input  wire ecte_pkg::req_type req_data,
   output      logic              rsp_empty,
   input  wire logic              rsp_pop,
   output      ecte_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [6:0]        csr_wdata
);

   ecte_pkg::job_type job_wr;
   ecte_pkg::job_type job_rd;
   logic              job_push;
   logic              job_pop;
   logic              job_empty;
   logic              item_valid;

   assign item_valid = req_push && !req_full;

   ecte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (req_data),
      .job_push   (job_push),
      .job        (job_wr)
   );

   ecte_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .wdata (job_wr),
      .pop   (job_pop),
      .rdata (job_rd),
      .full  (req_full),
      .empty (job_empty)
   );

   ecte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (job_rd),
      .head_empty (job_empty),
      .head_pop   (job_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: bench/tb_escape_command_text_encoder.sv
// Self-checking bench for the escape command text encoder: directed and random text.
`timescale 1ns / 1ps
module tb_escape_command_text_encoder;
   import ecte_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 200;
   localparam int CYCLE_LIMIT   = 200000;

   typedef enum int {
      END_AFTER_SEPARATOR,
      END_AFTER_TEXT,
      END_IN_ESCAPE,
      END_AT_BOUNDARY,
      END_AT_MIN_LIMIT
   } text_ending_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_push  = 1'b0;
   logic       req_full;
   req_type    req_data  = '0;
   logic       rsp_empty;
   logic       rsp_pop   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we    = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wdata = '0;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   items_sent    = 0;
   int   mismatches    = 0;
   int   cycle_count   = 0;
   logic hold_active   = 1'b0;
   event hold_go;

   logic [7:0] command_letters [8] = '{CHAR_UPPER_S, CHAR_LOWER_S, CHAR_UPPER_W, CHAR_LOWER_W,
                                       CHAR_UPPER_P, CHAR_LOWER_P, CHAR_UPPER_D, CHAR_LOWER_D};

   // encoder state as the bench sees it
   logic           cfg_ee_mode     = 1'b0;
   logic [6:0]     cfg_text_limit  = 7'd127;
   logic           esc_pending     = 1'b0;
   cmd_letter_type cmd_letter      = CMD_NONE;
   logic           after_separator = 1'b0;
   logic           separator_last  = 1'b0;
   logic [7:0]     write_count     = '0;
   logic           text_started    = 1'b0;
   logic           text_stopped    = 1'b0;
   logic [3:0]     picture_slot [PICTURE_SLOTS] = '{default: '0};
   int             picture_count   = 0;
   rsp_type        step_beats[$];
   rsp_type        predicted_beats[$];

   escape_command_text_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int room_left();
      int limit;
      limit = (cfg_text_limit > MEM_LAST_ADDR) ? int'(MEM_LAST_ADDR) : int'(cfg_text_limit);
      return limit - 8 * picture_count - int'(write_count);
   endfunction

   function automatic void add_beat(logic kind, logic [6:0] address, logic [7:0] data);
      rsp_type beat;
      if (step_beats.size() >= BEATS_PER_JOB) return;
      beat.kind    = kind;
      beat.address = address;
      beat.data    = data;
      beat.last    = 1'b0;
      step_beats.push_back(beat);
   endfunction

   function automatic void store_byte(logic [7:0] data);
      add_beat(KIND_WRITE, write_count[6:0], data);
      separator_last = (data == BYTE_SEPARATOR);
      write_count    = write_count + 8'd1;
   endfunction

   function automatic void take_argument(logic [7:0] c);
      cmd_letter_type letter;
      int             num;
      int             slot;
      letter     = cmd_letter;
      cmd_letter = CMD_NONE;
      if (c < CHAR_ONE || c > CHAR_NINE) return;
      num = int'(c) - int'(CHAR_ZERO);
      case (letter)
         CMD_SPEED: if (num <= 8) store_byte(8'(BYTE_SPEED + num - 1));
         CMD_WAIT:  if (num <= 8) store_byte(8'(BYTE_WAIT + num - 1));
         CMD_PICTURE: if (num <= PICTURE_SLOTS) begin
            slot = num - 1;
            if (!picture_slot[slot][3]) begin
               picture_slot[slot] = {1'b1, 3'(picture_count)};
               picture_count      = (picture_count + 1) & 15;
            end
            store_byte(8'(BYTE_PICTURE + picture_slot[slot][2:0]));
         end
         CMD_SPACER: if (num <= 2) store_byte(8'(BYTE_SPACER + num - 1));
         default: ;
      endcase
   endfunction

   function automatic void take_escaped(logic [7:0] c);
      esc_pending = 1'b0;
      case (c)
         CHAR_BACKSLASH:             store_byte(CHAR_BACKSLASH);
         CHAR_UPPER_I:               store_byte(BYTE_INVERT);
         CHAR_UPPER_H:               store_byte(BYTE_HOLD);
         CHAR_UPPER_S, CHAR_LOWER_S: cmd_letter = CMD_SPEED;
         CHAR_UPPER_W, CHAR_LOWER_W: cmd_letter = CMD_WAIT;
         CHAR_UPPER_P, CHAR_LOWER_P: cmd_letter = CMD_PICTURE;
         CHAR_UPPER_D, CHAR_LOWER_D: cmd_letter = CMD_SPACER;
         default:                    cmd_letter = CMD_OTHER;
      endcase
   endfunction

   function automatic void take_plain(logic [7:0] c);
      if (c == CHAR_NEWLINE) begin
         if (after_separator) begin
            after_separator = 1'b0;
         end else begin
            store_byte(BYTE_SEPARATOR);
            after_separator = 1'b1;
         end
         return;
      end
      after_separator = 1'b0;
      if (c == CHAR_BACKSLASH) begin
         esc_pending = 1'b1;
      end else if (c >= BYTE_SPACE) begin
         store_byte(c);
      end
   endfunction

   function automatic void encode_item(req_type item);
      step_beats.delete();
      if (text_stopped) return;
      if (!text_started) begin
         text_started = 1'b1;
         if (cfg_ee_mode) begin
            store_byte(BYTE_SPACE);
            store_byte(BYTE_SPACE);
         end
      end
      if (item.action == ACTION_END) begin
         // a trailing separator becomes the end marker in place
         if (separator_last && write_count > 0) begin
            add_beat(KIND_WRITE, 7'(write_count - 8'd1), BYTE_END);
            separator_last = 1'b0;
         end else begin
            store_byte(BYTE_END);
         end
         esc_pending  = 1'b0;
         cmd_letter   = CMD_NONE;
         text_stopped = 1'b1;
      end else if (cmd_letter != CMD_NONE) begin
         take_argument(item.code);
      end else if (room_left() <= 0) begin
         add_beat(KIND_OVERFLOW, '0, '0);
         text_stopped = 1'b1;
      end else if (esc_pending) begin
         take_escaped(item.code);
      end else begin
         take_plain(item.code);
      end
      if (step_beats.size() > 0) step_beats[$].last = 1'b1;
      foreach (step_beats[i]) predicted_beats.push_back(step_beats[i]);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (predicted_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, rsp_data);
            mismatches++;
         end else begin : compare_beat
            rsp_type want;
            want = predicted_beats.pop_front();
            check_field("kind", 8'(want.kind), 8'(rsp_data.kind));
            check_field("address", 8'(want.address), 8'(rsp_data.address));
            check_field("data", want.data, rsp_data.data);
            check_field("last", 8'(want.last), 8'(rsp_data.last));
         end
      end
   end

   always @(negedge clock) begin
      rsp_pop <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      forever begin
         @(hold_go);
         @(posedge clock);
         hold_active = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("escape_command_text_encoder verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic action, input logic [7:0] code);
      req_type item;
      item.action = action;
      item.code   = code;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      encode_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] code);
      send_item(ACTION_TEXT, code);
   endtask

   task automatic send_command(input logic [7:0] letter, input logic [7:0] arg);
      send_text(CHAR_BACKSLASH);
      send_text(letter);
      send_text(arg);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (predicted_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [6:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_EE_MODE) cfg_ee_mode = value[0];
      else cfg_text_limit = value;
      @(negedge clock);
   endtask

   task automatic send_random_token();
      int         pick;
      int         room;
      int         idx;
      int         top;
      logic [7:0] c;
      room = room_left();
      pick = $urandom_range(99);
      if (room <= 3 || (pick >= 75 && room <= 16)) begin
         // close to the limit: only items that write nothing
         if ($urandom_range(1)) begin
            c = 8'($urandom_range(31));
            if (c == CHAR_NEWLINE) c = 8'h09;
            send_text(c);
         end else begin
            c = 8'($urandom_range(255));
            if (c inside {CHAR_BACKSLASH, CHAR_UPPER_I, CHAR_UPPER_H, CHAR_UPPER_S, CHAR_LOWER_S,
                          CHAR_UPPER_W, CHAR_LOWER_W, CHAR_UPPER_P, CHAR_LOWER_P,
                          CHAR_UPPER_D, CHAR_LOWER_D}) c = 8'h3F;
            send_command(c, 8'($urandom_range(255)));
         end
      end else if (pick < 35) begin
         c = 8'($urandom_range(255, 32));
         if (c == CHAR_BACKSLASH) c = 8'h2F;
         send_text(c);
      end else if (pick < 45) begin
         send_text(CHAR_NEWLINE);
      end else if (pick < 55) begin
         idx = $urandom_range(2);
         send_text(CHAR_BACKSLASH);
         send_text(idx == 0 ? CHAR_BACKSLASH : (idx == 1 ? CHAR_UPPER_I : CHAR_UPPER_H));
      end else if (pick < 75) begin
         idx = $urandom_range(7);
         if (room <= 16 && command_letters[idx] inside {CHAR_UPPER_P, CHAR_LOWER_P}) idx = 0;
         top = (command_letters[idx] inside {CHAR_UPPER_D, CHAR_LOWER_D}) ? 2 : 8;
         send_command(command_letters[idx], 8'(CHAR_ZERO + $urandom_range(top, 1)));
      end else if (pick < 85) begin
         send_text(8'($urandom_range(31)));
      end else if (pick < 93) begin
         send_text(CHAR_BACKSLASH);
         send_text(8'($urandom_range(255)));
         if (cmd_letter != CMD_NONE) send_text(8'($urandom_range(255)));
      end else begin
         idx = $urandom_range(7);
         top = $urandom_range(2);
         send_command(command_letters[idx], top == 0 ? CHAR_ZERO :
                      (top == 1 ? CHAR_NINE : 8'($urandom_range(255))));
      end
   endtask

   task automatic test_register_setup();
      write_csr(CSR_EE_MODE, 7'd1);
      write_csr(CSR_TEXT_LIMIT, 7'd127);
   endtask

   task automatic test_directed_text();
      send_idle_pct = 12;
      recv_idle_pct = 71;
      send_text(8'h41);
      send_text(8'hFF);
      send_text(8'h00);
      send_text(8'h1F);
      send_text(CHAR_NEWLINE);
      send_text(CHAR_NEWLINE);
      send_text(CHAR_BACKSLASH);
      send_text(CHAR_BACKSLASH);
      send_text(CHAR_BACKSLASH);
      send_text(CHAR_UPPER_I);
      send_text(CHAR_BACKSLASH);
      send_text(CHAR_UPPER_H);
      send_command(CHAR_UPPER_S, CHAR_ONE);
      send_command(CHAR_LOWER_W, 8'h38);
      send_command(CHAR_UPPER_P, 8'h38);
      send_command(CHAR_LOWER_D, 8'h32);
      send_command(8'h58, CHAR_ZERO);
   endtask

   task automatic test_backpressure();
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      -> hold_go;
      repeat (12) send_text(8'($urandom_range(91, 32)));
      wait_idle();
   endtask

   task automatic test_random_text(input int items, input int send_pct, input int recv_pct,
                                   input bit pick_limit);
      int stop_at;
      int lo;
      wait_idle();
      write_csr(CSR_EE_MODE, 7'($urandom_range(1)));
      lo = int'(write_count) + 8 * picture_count + 12;
      if (lo > 127) lo = 127;
      write_csr(CSR_TEXT_LIMIT, pick_limit ? 7'($urandom_range(127, lo)) : 7'd127);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = items_sent + items;
      while (items_sent < stop_at) send_random_token();
   endtask

   task automatic test_text_ending();
      text_ending_type ending;
      int              boundary;
      ending = text_ending_type'($urandom_range(4));
      send_idle_pct = 12;
      recv_idle_pct = 71;
      case (ending)
         END_AFTER_SEPARATOR: begin
            send_text(CHAR_NEWLINE);
            send_item(ACTION_END, 8'($urandom_range(255)));
         end
         END_AFTER_TEXT: begin
            send_text(8'h5A);
            send_item(ACTION_END, 8'($urandom_range(255)));
         end
         END_IN_ESCAPE: begin
            send_text(CHAR_BACKSLASH);
            if ($urandom_range(1)) send_text(CHAR_UPPER_S);
            send_item(ACTION_END, 8'($urandom_range(255)));
         end
         END_AT_BOUNDARY: begin
            wait_idle();
            boundary = int'(write_count) + 8 * picture_count + $urandom_range(1);
            if (boundary > 127) boundary = 127;
            write_csr(CSR_TEXT_LIMIT, 7'(boundary));
            while (!text_stopped) send_text(8'h42);
         end
         default: begin
            wait_idle();
            write_csr(CSR_TEXT_LIMIT, 7'd8);
            send_text(8'h41);
         end
      endcase
      // stopped: everything below must be dropped
      repeat (6) send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      wait_idle();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_register_setup();
      test_directed_text();
      test_backpressure();
      test_random_text(110, 12, 71, 1'b0);
      test_random_text(110, 71, 12, 1'b1);
      test_random_text(110, 0, 0, 1'b0);
      test_text_ending();
      if (mismatches == 0) begin
         $display("escape_command_text_encoder verification clean");
      end else begin
         $display("escape_command_text_encoder verification failed");
      end
      $finish;
   end

endmodule
